@@ src/pcs_pkg.sv @@
// shared types and constants of the pedal plausibility check and scaler
`default_nettype none
package pcs_pkg;

   localparam int LIMIT_W    = 10;
   localparam int MARGIN_W   = 8;
   localparam int TRIM_W     = 2;
   localparam int SPAN_W     = 11;
   localparam int QUOT_W     = 8;
   localparam int NUM_W      = SPAN_W + QUOT_W;
   localparam int PCT_W      = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [LIMIT_W-1:0]  RST_FIRST_LOW   = 10'd290;
   localparam logic [LIMIT_W-1:0]  RST_FIRST_HIGH  = 10'd465;
   localparam logic [LIMIT_W-1:0]  RST_SECOND_LOW  = 10'd345;
   localparam logic [LIMIT_W-1:0]  RST_SECOND_HIGH = 10'd535;
   localparam logic [MARGIN_W-1:0] RST_MARGIN      = 8'd10;
   localparam logic [LIMIT_W-1:0]  RST_DELTA_LOW   = 10'd0;
   localparam logic [LIMIT_W-1:0]  RST_DELTA_HIGH  = 10'd1023;
   localparam logic [TRIM_W-1:0]   RST_TRIM        = 2'd3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FIRST_LOW   = 3'd0,
      CSR_FIRST_HIGH  = 3'd1,
      CSR_SECOND_LOW  = 3'd2,
      CSR_SECOND_HIGH = 3'd3,
      CSR_MARGIN      = 3'd4,
      CSR_DELTA_LOW   = 3'd5,
      CSR_DELTA_HIGH  = 3'd6,
      CSR_TRIM        = 3'd7
   } pcs_csr_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]  first_low;
      logic [LIMIT_W-1:0]  first_high;
      logic [LIMIT_W-1:0]  second_low;
      logic [LIMIT_W-1:0]  second_high;
      logic [MARGIN_W-1:0] margin;
      logic [LIMIT_W-1:0]  delta_low;
      logic [LIMIT_W-1:0]  delta_high;
      logic [TRIM_W-1:0]   trim;
   } pcs_cfg_type;

   typedef struct packed {
      logic               fault;
      logic               force_q;
      logic [NUM_W-1:0]   rem;
      logic [SPAN_W-1:0]  span;
      logic [QUOT_W-1:0]  quot;
   } pcs_word_type;

endpackage
`default_nettype wire

@@ src/pcs_check_cell.sv @@
// front cell: window and delta checks, clamping, dividend and divisor setup
`default_nettype none
module pcs_check_cell #(
   parameter int SAMPLE_BITS = 10,
   parameter int FULL_SCALE  = 100
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pcs_pkg::pcs_cfg_type     cfg,
   input  wire logic                     up_valid,
   output logic                          up_ready,
   input  wire logic [SAMPLE_BITS-1:0]   first_sample,
   input  wire logic [SAMPLE_BITS-1:0]   second_sample,
   output logic                          dn_valid,
   input  wire logic                     dn_ready,
   output pcs_pkg::pcs_word_type         dn_word
);
   import pcs_pkg::*;

   localparam int CW = ((SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W) + 2;
   localparam logic [QUOT_W-1:0] FS_K = QUOT_W'(FULL_SCALE);

   logic               valid_ff, valid_in;
   pcs_word_type       word_ff, word_in;
   logic signed [CW-1:0] a_s, b_s, lo1, hi1, lo2, hi2, mrg, dlo, dhi, trm, dif;
   logic signed [CW-1:0] diff_full, span_full;
   logic               fault_c, high_cut, low_cut;
   logic [SPAN_W-1:0]  diff, span;
   logic [NUM_W-1:0]   num;

   always_comb begin
      a_s = $signed({{(CW-SAMPLE_BITS){1'b0}}, first_sample});
      b_s = $signed({{(CW-SAMPLE_BITS){1'b0}}, second_sample});
      lo1 = $signed({{(CW-LIMIT_W){1'b0}}, cfg.first_low});
      hi1 = $signed({{(CW-LIMIT_W){1'b0}}, cfg.first_high});
      lo2 = $signed({{(CW-LIMIT_W){1'b0}}, cfg.second_low});
      hi2 = $signed({{(CW-LIMIT_W){1'b0}}, cfg.second_high});
      dlo = $signed({{(CW-LIMIT_W){1'b0}}, cfg.delta_low});
      dhi = $signed({{(CW-LIMIT_W){1'b0}}, cfg.delta_high});
      mrg = $signed({{(CW-MARGIN_W){1'b0}}, cfg.margin});
      trm = $signed({{(CW-TRIM_W){1'b0}}, cfg.trim});
      dif = (a_s > b_s) ? (a_s - b_s) : (b_s - a_s);
      fault_c = (a_s < lo1 - mrg) || (a_s > hi1 + mrg) ||
                (b_s < lo2 - mrg) || (b_s > hi2 + mrg) ||
                (dif < dlo) || (dif > dhi);
      high_cut  = a_s > hi1;
      low_cut   = a_s < lo1;
      diff_full = a_s - lo1 + trm;
      span_full = hi1 - lo1 + trm + trm;
      diff      = diff_full[SPAN_W-1:0];
      span      = span_full[SPAN_W-1:0];
      num       = diff * FS_K;
   end

   always_comb begin
      word_in.fault   = fault_c;
      word_in.force_q = 1'b1;
      word_in.rem     = num;
      word_in.span    = span;
      word_in.quot    = '0;
      if (fault_c) begin
         word_in.quot = '0;
      end else if (high_cut) begin
         word_in.quot = FS_K;
      end else if (low_cut || (span == '0)) begin
         word_in.quot = '0;
      end else begin
         word_in.force_q = 1'b0;
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule
`default_nettype wire

@@ src/pcs_div_cell.sv @@
// divider cell: settles one quotient bit by compare and subtract
`default_nettype none
module pcs_div_cell #(
   parameter int BIT_POS = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  up_valid,
   output logic                       up_ready,
   input  wire pcs_pkg::pcs_word_type up_word,
   output logic                       dn_valid,
   input  wire logic                  dn_ready,
   output pcs_pkg::pcs_word_type      dn_word
);
   import pcs_pkg::*;

   logic             valid_ff, valid_in;
   pcs_word_type     word_ff, word_in;
   logic [NUM_W-1:0] dvs;

   always_comb begin
      dvs     = NUM_W'(up_word.span) << BIT_POS;
      word_in = up_word;
      if (!up_word.force_q && (up_word.rem >= dvs)) begin
         word_in.rem           = up_word.rem - dvs;
         word_in.quot[BIT_POS] = 1'b1;
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule
`default_nettype wire

@@ src/dual_channel_pedal_check_scale_top.sv @@
// top level of the dual channel pedal plausibility check and scaler
//
// Takes one pair of pedal samples per word and returns one word with the pedal
// position in percent and a fault flag. Up to one word is accepted every cycle;
// a result passes through the check cell, then through one divider cell per
// quotient bit. Every cell holds its own word, so a stall on the result side
// only fills empty cells before input is held off.
`default_nettype none
module dual_channel_pedal_check_scale_top #(
   parameter int SAMPLE_BITS = 10,
   parameter int FULL_SCALE  = 100
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // first_sample, second_sample, zero fill
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // pedal_percent, zero fill
   output logic [7:0]                                rsp_tdata,
   // fault
   output logic [0:0]                                rsp_tuser,
   input  wire logic                                 csr_we,
   input  wire logic [pcs_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [pcs_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import pcs_pkg::*;

   localparam int QB = $clog2(FULL_SCALE + 1);

   pcs_cfg_type  cfg_ff, cfg_in;
   logic         vld [QB+1];
   logic         rdy [QB+1];
   pcs_word_type word [QB+1];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (pcs_csr_type'(csr_addr))
            CSR_FIRST_LOW:   cfg_in.first_low   = csr_wdata[LIMIT_W-1:0];
            CSR_FIRST_HIGH:  cfg_in.first_high  = csr_wdata[LIMIT_W-1:0];
            CSR_SECOND_LOW:  cfg_in.second_low  = csr_wdata[LIMIT_W-1:0];
            CSR_SECOND_HIGH: cfg_in.second_high = csr_wdata[LIMIT_W-1:0];
            CSR_MARGIN:      cfg_in.margin      = csr_wdata[MARGIN_W-1:0];
            CSR_DELTA_LOW:   cfg_in.delta_low   = csr_wdata[LIMIT_W-1:0];
            CSR_DELTA_HIGH:  cfg_in.delta_high  = csr_wdata[LIMIT_W-1:0];
            CSR_TRIM:        cfg_in.trim        = csr_wdata[TRIM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_low   <= RST_FIRST_LOW;
         cfg_ff.first_high  <= RST_FIRST_HIGH;
         cfg_ff.second_low  <= RST_SECOND_LOW;
         cfg_ff.second_high <= RST_SECOND_HIGH;
         cfg_ff.margin      <= RST_MARGIN;
         cfg_ff.delta_low   <= RST_DELTA_LOW;
         cfg_ff.delta_high  <= RST_DELTA_HIGH;
         cfg_ff.trim        <= RST_TRIM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pcs_check_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FULL_SCALE  (FULL_SCALE)
   ) u_check (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .up_valid      (req_tvalid),
      .up_ready      (req_tready),
      .first_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .second_sample (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .dn_valid      (vld[0]),
      .dn_ready      (rdy[0]),
      .dn_word       (word[0])
   );

   // msb of the quotient first
   for (genvar k = 0; k < QB; k++) begin : g_div
      pcs_div_cell #(
         .BIT_POS (QB - 1 - k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (vld[k]),
         .up_ready (rdy[k]),
         .up_word  (word[k]),
         .dn_valid (vld[k+1]),
         .dn_ready (rdy[k+1]),
         .dn_word  (word[k+1])
      );
   end

   assign rdy[QB]    = rsp_tready;
   assign rsp_tvalid = vld[QB];
   assign rsp_tdata  = {1'b0, PCT_W'(word[QB].quot)};
   assign rsp_tuser  = word[QB].fault;

endmodule
`default_nettype wire

@@ src/pcs_checker.sv @@
// port level checks on the pedal check top, attached by bind
`default_nettype none
module pcs_checker #(
   parameter int FULL_SCALE  = 100
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [7:0]                          rsp_tdata,
   input wire logic [0:0]                          rsp_tuser
);

   // nothing comes out right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // a faulted word carries zero percent
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[6:0] == 7'd0))
      else $error("faulted word with nonzero percent");

   // percent within full scale, fill bit clear
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((32'(rsp_tdata[6:0]) <= 32'(FULL_SCALE)) && !rsp_tdata[7]))
      else $error("percent out of range");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

endmodule

bind dual_channel_pedal_check_scale_top pcs_checker #(
   .FULL_SCALE  (FULL_SCALE)
) u_pcs_checker (.*);
`default_nettype wire
